// ===== rtl/pia_pkg.sv =====
// pia_pkg: shared types and constants for the process-id slot allocator
// field widths, request and status codes, fsm states, table command structs
// no dependencies
package pia_pkg;

    // payload field widths
    localparam int ID_W     = 15;
    localparam int CODE_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // parameter defaults
    localparam int DEF_TABLE_SLOTS = 128;
    localparam int DEF_ID_LOW      = 2;
    localparam int DEF_ID_HIGH     = 32767;
    localparam int DEF_BOOT_ID     = 1;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXIT    = 2'd2;

    // response status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_ID   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd3;

    // marks written into the status store
    localparam logic [CODE_W-1:0] MARK_ALLOC   = 32'h0000_BEEF;
    localparam logic [CODE_W-1:0] MARK_RELEASE = 32'h0000_DEAD;

    // invalid id, used as parent of the boot process
    localparam logic [ID_W-1:0] NO_ID = '0;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOD,
        ST_CHECK,
        ST_HOLD
    } pia_state_t;

    // table update operations
    typedef enum logic [1:0] {
        TBL_NONE,
        TBL_ALLOC,
        TBL_RELEASE,
        TBL_EXIT
    } tbl_op_t;

    // update command from controller to table
    typedef struct packed {
        tbl_op_t             op;
        logic [ID_W-1:0]     owner;
        logic [ID_W-1:0]     parent;
        logic [CODE_W-1:0]   code;
    } tbl_cmd_t;

    // lookup result from table to controller
    typedef struct packed {
        logic                used;
        logic                exited;
        logic [ID_W-1:0]     owner;
        logic [ID_W-1:0]     parent;
    } tbl_rd_t;

endpackage

// ===== rtl/pia_if.sv =====
// pia_req_if / pia_rsp_if: valid-ready channels of the allocator
// request word carries kind and ids, response word carries status and id
// depends on pia_pkg
interface pia_req_if import pia_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [ID_W-1:0]          target_id;
    logic [ID_W-1:0]          caller_id;
    logic signed [CODE_W-1:0] exit_code;

    modport source (output valid, kind, target_id, caller_id, exit_code, input ready);
    modport sink   (input valid, kind, target_id, caller_id, exit_code, output ready);
endinterface

interface pia_rsp_if import pia_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [ID_W-1:0]       granted_id;

    modport source (output valid, status, granted_id, input ready);
    modport sink   (input valid, status, granted_id, output ready);
endinterface

// ===== rtl/pia_slot_mod.sv =====
// pia_slot_mod: remainder unit, id mod TABLE_SLOTS by reciprocal multiplication
// three steps: quotient estimate, multiply back and subtract, one final correction
// depends on pia_pkg
module pia_slot_mod import pia_pkg::*; #(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ID_W-1:0]                value,
    output logic                           done,
    output logic [$clog2(TABLE_SLOTS)-1:0] slot
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    // floor(2^ID_W / TABLE_SLOTS): the quotient estimate is short by at most one
    localparam logic [ID_W-1:0] RECIP   = ID_W'((1 << ID_W) / TABLE_SLOTS);
    localparam logic [ID_W:0]   DIVISOR = (ID_W + 1)'(TABLE_SLOTS);

    logic [ID_W-1:0]   value_reg, value_next;
    logic [ID_W-1:0]   quot_reg, quot_next;
    logic [ID_W-1:0]   rem_reg, rem_next;
    logic              mul_reg;
    logic              sub_reg;
    logic              fix_reg;
    logic              done_reg;
    logic [2*ID_W-1:0] product;
    logic [ID_W:0]     back;
    logic [ID_W-1:0]   corrected;

    // quotient estimate, multiply back, final correction
    always_comb
    begin
        product   = {{ID_W{1'b0}}, value_reg} * {{ID_W{1'b0}}, RECIP};
        back      = {1'b0, quot_reg} * DIVISOR;
        corrected = (rem_reg >= DIVISOR[ID_W-1:0]) ? rem_reg - DIVISOR[ID_W-1:0] : rem_reg;
    end

    // data step selection
    always_comb
    begin
        value_next = value_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            value_next = value;
        end
        if (mul_reg)
        begin
            quot_next = product[2*ID_W-1:ID_W];
        end
        if (sub_reg)
        begin
            rem_next = value_reg - back[ID_W-1:0];
        end
        else if (fix_reg)
        begin
            rem_next = corrected;
        end
    end

    // step flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= start;
            sub_reg  <= mul_reg;
            fix_reg  <= sub_reg;
            done_reg <= fix_reg;
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign slot = rem_reg[SLOT_W-1:0];

endmodule

// ===== rtl/pia_table.sv =====
// pia_table: process table, used and exited flags in flops, ids and status in memory
// one lookup port with registered read, one update port, scan probe of used flags
// depends on pia_pkg
module pia_table import pia_pkg::*; #(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int BOOT_ID     = DEF_BOOT_ID
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(TABLE_SLOTS)-1:0] scan_slot,
    output logic                           scan_used,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_SLOTS)-1:0] rd_slot,
    output tbl_rd_t                        rd,
    input  logic [$clog2(TABLE_SLOTS)-1:0] wr_slot,
    input  tbl_cmd_t                       cmd
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] BOOT_SLOT = SLOT_W'(BOOT_ID % TABLE_SLOTS);

    logic [TABLE_SLOTS-1:0]  used_reg, used_next;
    logic [TABLE_SLOTS-1:0]  exited_reg, exited_next;
    logic                    boot_fresh_reg, boot_fresh_next;
    logic [2*ID_W-1:0]       ids_mem [TABLE_SLOTS];
    logic [CODE_W-1:0]       status_mem [TABLE_SLOTS];
    logic [2*ID_W-1:0]       ids_rd_reg;
    logic [SLOT_W-1:0]       rd_slot_reg;
    logic                    status_we;
    logic [CODE_W-1:0]       status_wdata;

    // flag updates
    always_comb
    begin
        used_next       = used_reg;
        exited_next     = exited_reg;
        boot_fresh_next = boot_fresh_reg;
        status_we       = 1'b0;
        status_wdata    = cmd.code;
        case (cmd.op)
            TBL_ALLOC:
            begin
                used_next[wr_slot]   = 1'b1;
                exited_next[wr_slot] = 1'b0;
                status_we            = 1'b1;
                status_wdata         = MARK_ALLOC;
                if (wr_slot == BOOT_SLOT)
                begin
                    boot_fresh_next = 1'b0;
                end
            end
            TBL_RELEASE:
            begin
                used_next[wr_slot]   = 1'b0;
                exited_next[wr_slot] = 1'b0;
                status_we            = 1'b1;
                status_wdata         = MARK_RELEASE;
            end
            TBL_EXIT:
            begin
                exited_next[wr_slot] = 1'b1;
                status_we            = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // flag registers, boot slot live at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= {{(TABLE_SLOTS-1){1'b0}}, 1'b1} << BOOT_SLOT;
            exited_reg     <= '0;
            boot_fresh_reg <= 1'b1;
        end
        else
        begin
            used_reg       <= used_next;
            exited_reg     <= exited_next;
            boot_fresh_reg <= boot_fresh_next;
        end
    end

    // id memory: owner and parent, written on allocate
    always_ff @(posedge clk)
    begin
        if (cmd.op == TBL_ALLOC)
        begin
            ids_mem[wr_slot] <= {cmd.owner, cmd.parent};
        end
        if (rd_en)
        begin
            ids_rd_reg  <= ids_mem[rd_slot];
            rd_slot_reg <= rd_slot;
        end
    end

    // exit status memory
    always_ff @(posedge clk)
    begin
        if (status_we)
        begin
            status_mem[wr_slot] <= status_wdata;
        end
    end

    // lookup result, boot entry reads its reset ids until reallocated
    always_comb
    begin
        rd.used   = used_reg[rd_slot_reg];
        rd.exited = exited_reg[rd_slot_reg];
        if (boot_fresh_reg && rd_slot_reg == BOOT_SLOT)
        begin
            rd.owner  = ID_W'(BOOT_ID);
            rd.parent = NO_ID;
        end
        else
        begin
            rd.owner  = ids_rd_reg[2*ID_W-1:ID_W];
            rd.parent = ids_rd_reg[ID_W-1:0];
        end
    end

    assign scan_used = used_reg[scan_slot];

endmodule

// ===== rtl/process_id_slot_allocator.sv =====
// channel | dir | word fields
// req     | in  | kind, target_id, caller_id, exit_code
// rsp     | out | status, granted_id
//
// allocate: probes 1 to 2*TABLE_SLOTS+6 slots from the candidate,
//   one used-flag probe per cycle in the scan loop
// release / exit: the target goes through the three-step remainder unit, whose done pulse
//   starts the registered table read, then the check; rejected words go straight to ST_HOLD
// reset clears all control state at once; no clearing pass, boot process is live
// req is taken whenever the controller is idle, also while a response waits on rsp;
//   a finished result then holds until the response register frees up
// depends on pia_pkg, pia_if, pia_slot_mod, pia_table
module process_id_slot_allocator import pia_pkg::*; #(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int ID_LOW      = DEF_ID_LOW,
    parameter int ID_HIGH     = DEF_ID_HIGH,
    parameter int BOOT_ID     = DEF_BOOT_ID
) (
    input  logic        clk,
    input  logic        rst_n,
    pia_req_if.sink     req,
    pia_rsp_if.source   rsp
);

    localparam int SLOT_W     = $clog2(TABLE_SLOTS);
    localparam int LIVE_W     = $clog2(TABLE_SLOTS + 1);
    localparam int SCAN_LIMIT = 2 * TABLE_SLOTS + 5;
    localparam int SCAN_W     = $clog2(SCAN_LIMIT + 1);
    localparam logic [SLOT_W-1:0] LOW_SLOT = SLOT_W'(ID_LOW % TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    pia_state_t            state_reg, state_next;
    logic [KIND_W-1:0]     kind_reg;
    logic [ID_W-1:0]       target_reg;
    logic [ID_W-1:0]       caller_reg;
    logic [CODE_W-1:0]     code_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [ID_W-1:0]       cand_reg, cand_next;
    logic [SLOT_W-1:0]     cand_slot_reg, cand_slot_next;
    logic [SCAN_W-1:0]     steps_reg;
    logic [LIVE_W-1:0]     live_count_reg;
    logic [STATUS_W-1:0]   res_status_reg, res_status;
    logic [ID_W-1:0]       res_granted_reg, res_granted;
    logic                  res_load;
    logic                  rsp_valid_reg;
    logic [STATUS_W-1:0]   rsp_status_reg;
    logic [ID_W-1:0]       rsp_granted_reg;

    logic                  accept;
    pia_state_t            acc_state;
    logic [STATUS_W-1:0]   acc_status;
    logic                  scan_used;
    logic                  mod_done;
    logic [SLOT_W-1:0]     mod_slot;
    tbl_rd_t               rd;
    tbl_cmd_t              cmd;
    logic [SLOT_W-1:0]     wr_slot;
    logic                  present;
    logic                  cand_adv;
    logic                  live_inc;
    logic                  live_dec;
    logic                  rsp_free;

    // shared remainder unit for target slot lookup
    pia_slot_mod #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_slot_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && acc_state == ST_MOD),
        .value (req.target_id),
        .done  (mod_done),
        .slot  (mod_slot)
    );

    // process table
    pia_table #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .BOOT_ID     (BOOT_ID)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan_slot (cand_slot_reg),
        .scan_used (scan_used),
        .rd_en     (state_reg == ST_MOD && mod_done),
        .rd_slot   (mod_slot),
        .rd        (rd),
        .wr_slot   (wr_slot),
        .cmd       (cmd)
    );

    assign accept   = req.valid && req.ready;
    assign present  = rd.used && rd.owner == target_reg;
    assign rsp_free = !rsp_valid_reg || rsp.ready;

    // candidate advance, wrapping over the id range
    always_comb
    begin
        if (cand_reg == ID_W'(ID_HIGH))
        begin
            cand_next      = ID_W'(ID_LOW);
            cand_slot_next = LOW_SLOT;
        end
        else
        begin
            cand_next      = cand_reg + ID_W'(1);
            cand_slot_next = (cand_slot_reg == LAST_SLOT) ? '0 : cand_slot_reg + SLOT_W'(1);
        end
    end

    // request decode at accept
    always_comb
    begin
        acc_state  = ST_HOLD;
        acc_status = STATUS_REFUSED;
        unique case (req.kind)
            KIND_ALLOC:
            begin
                if (live_count_reg >= LIVE_W'(TABLE_SLOTS))
                begin
                    acc_status = STATUS_FULL;
                end
                else
                begin
                    acc_state = ST_SCAN;
                end
            end
            KIND_RELEASE:
            begin
                if (req.target_id < ID_W'(ID_LOW) || req.target_id > ID_W'(ID_HIGH))
                begin
                    acc_status = STATUS_NO_ID;
                end
                else
                begin
                    acc_state = ST_MOD;
                end
            end
            KIND_EXIT:
            begin
                if (req.target_id == NO_ID)
                begin
                    acc_status = STATUS_NO_ID;
                end
                else
                begin
                    acc_state = ST_MOD;
                end
            end
            default:
            begin
                acc_status = STATUS_REFUSED;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = acc_state;
                end
            end
            ST_SCAN:
            begin
                if (!scan_used || steps_reg == SCAN_W'(SCAN_LIMIT))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: table command, result, counters
    always_comb
    begin
        req.ready   = 1'b0;
        cmd.op      = TBL_NONE;
        cmd.owner   = cand_reg;
        cmd.parent  = caller_reg;
        cmd.code    = code_reg;
        wr_slot     = slot_reg;
        res_load    = 1'b0;
        res_status  = STATUS_OK;
        res_granted = '0;
        cand_adv    = 1'b0;
        live_inc    = 1'b0;
        live_dec    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid && acc_state == ST_HOLD)
                begin
                    res_load   = 1'b1;
                    res_status = acc_status;
                end
            end
            ST_SCAN:
            begin
                wr_slot = cand_slot_reg;
                if (!scan_used)
                begin
                    cmd.op      = TBL_ALLOC;
                    res_load    = 1'b1;
                    res_granted = cand_reg;
                    cand_adv    = 1'b1;
                    live_inc    = 1'b1;
                end
                else if (steps_reg == SCAN_W'(SCAN_LIMIT))
                begin
                    res_load   = 1'b1;
                    res_status = STATUS_FULL;
                end
                else
                begin
                    cand_adv = 1'b1;
                end
            end
            ST_CHECK:
            begin
                res_load = 1'b1;
                if (!present)
                begin
                    res_status = STATUS_NO_ID;
                end
                else if (kind_reg == KIND_EXIT)
                begin
                    cmd.op = TBL_EXIT;
                end
                else if (rd.exited || rd.parent != caller_reg)
                begin
                    res_status = STATUS_REFUSED;
                end
                else
                begin
                    cmd.op   = TBL_RELEASE;
                    live_dec = live_count_reg != '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cand_reg       <= ID_W'(ID_LOW);
            cand_slot_reg  <= LOW_SLOT;
            steps_reg      <= '0;
            live_count_reg <= LIVE_W'(1);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cand_adv)
            begin
                cand_reg      <= cand_next;
                cand_slot_reg <= cand_slot_next;
            end
            if (accept)
            begin
                steps_reg <= '0;
            end
            else if (cand_adv)
            begin
                steps_reg <= steps_reg + SCAN_W'(1);
            end
            if (live_inc)
            begin
                live_count_reg <= live_count_reg + LIVE_W'(1);
            end
            else if (live_dec)
            begin
                live_count_reg <= live_count_reg - LIVE_W'(1);
            end
            if (state_reg == ST_HOLD && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // request and result words
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= req.kind;
            target_reg <= req.target_id;
            caller_reg <= req.caller_id;
            code_reg   <= req.exit_code;
        end
        if (state_reg == ST_MOD && mod_done)
        begin
            slot_reg <= mod_slot;
        end
        if (res_load)
        begin
            res_status_reg  <= res_status;
            res_granted_reg <= res_granted;
        end
        if (state_reg == ST_HOLD && rsp_free)
        begin
            rsp_status_reg  <= res_status_reg;
            rsp_granted_reg <= res_granted_reg;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.granted_id = rsp_granted_reg;

    // live count never exceeds the table
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_count_reg <= LIVE_W'(TABLE_SLOTS))
        else $error("live count above table size");

    // scan never runs past its step limit
    a_scan_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> steps_reg <= SCAN_W'(SCAN_LIMIT))
        else $error("scan ran past its limit");

    // a granted id lies in the id range
    a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.granted_id != NO_ID |->
            rsp.status == STATUS_OK && rsp.granted_id >= ID_W'(ID_LOW)
            && rsp.granted_id <= ID_W'(ID_HIGH))
        else $error("granted id outside range");

    // an allocation raises the live count by one
    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == TBL_ALLOC |=> live_count_reg == $past(live_count_reg) + LIVE_W'(1))
        else $error("live count not advanced on allocate");

endmodule

// ===== verif/process_id_slot_allocator_tb.sv =====
`timescale 1ns / 1ps
// process_id_slot_allocator_tb: self-checking bench for the process-id allocator
// a shadow of the slot table predicts every response word, checked in arrival order
// depends on pia_pkg, pia_req_if / pia_rsp_if and process_id_slot_allocator
module process_id_slot_allocator_tb;
    import pia_pkg::*;

    localparam int SLOTS        = DEF_TABLE_SLOTS;
    localparam int FIRST_ID     = DEF_ID_LOW;
    localparam int LAST_ID      = DEF_ID_HIGH;
    localparam int BOOT         = DEF_BOOT_ID;
    localparam int SCAN_MAX     = 2 * SLOTS + 5;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 40;
    localparam int CYCLE_LIMIT  = 1_500_000;

    // request kind with no operation behind it
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     granted_id;
    } pid_reply_t;

    // which live entries a stimulus pick may return
    typedef enum {
        PICK_ANY,
        PICK_RUNNING,
        PICK_EXITED
    } pick_mode_t;

    // shadow of the slot table: predicts each response word and checks it
    class pid_table_shadow;
        bit                in_use     [SLOTS];
        logic [ID_W-1:0]   holder     [SLOTS];
        logic [ID_W-1:0]   parent_of  [SLOTS];
        bit                has_exited [SLOTS];
        logic [CODE_W-1:0] exit_value [SLOTS];
        int unsigned       candidate;
        int unsigned       live;
        int unsigned       wraps;
        logic [ID_W-1:0]   last_grant;
        int unsigned       errors;
        pid_reply_t        replies_due[$];

        function void clear();
            for (int i = 0; i < SLOTS; i++)
            begin
                in_use[i]     = 1'b0;
                holder[i]     = '0;
                parent_of[i]  = NO_ID;
                has_exited[i] = 1'b0;
                exit_value[i] = '0;
            end
            // boot process is live from reset
            in_use[BOOT % SLOTS]     = 1'b1;
            holder[BOOT % SLOTS]     = ID_W'(BOOT);
            exit_value[BOOT % SLOTS] = MARK_ALLOC;
            candidate  = FIRST_ID;
            live       = 1;
            wraps      = 0;
            last_grant = '0;
            errors     = 0;
            replies_due.delete();
        endfunction

        function void step_candidate();
            candidate++;
            if (candidate > LAST_ID)
            begin
                candidate = FIRST_ID;
                wraps++;
            end
        endfunction

        // apply one accepted request word and queue the response it must give
        function void note_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] target,
                                   logic [ID_W-1:0] caller, logic [CODE_W-1:0] code);
            pid_reply_t  r;
            int unsigned steps;
            int unsigned s;
            r.status     = STATUS_OK;
            r.granted_id = '0;
            s = target % SLOTS;
            case (kind)
                KIND_ALLOC:
                begin
                    if (live >= SLOTS)
                        r.status = STATUS_FULL;
                    else
                    begin
                        // next-fit scan, bounded
                        steps = 0;
                        while (in_use[candidate % SLOTS] && steps < SCAN_MAX)
                        begin
                            step_candidate();
                            steps++;
                        end
                        s = candidate % SLOTS;
                        if (in_use[s])
                            r.status = STATUS_FULL;
                        else
                        begin
                            in_use[s]     = 1'b1;
                            holder[s]     = candidate[ID_W-1:0];
                            parent_of[s]  = caller;
                            has_exited[s] = 1'b0;
                            exit_value[s] = MARK_ALLOC;
                            live++;
                            r.granted_id  = candidate[ID_W-1:0];
                            last_grant    = candidate[ID_W-1:0];
                            step_candidate();
                        end
                    end
                end
                KIND_RELEASE:
                begin
                    if (target < FIRST_ID || target > LAST_ID)
                        r.status = STATUS_NO_ID;
                    else if (!in_use[s] || holder[s] != target)
                        r.status = STATUS_NO_ID;
                    else if (has_exited[s] || parent_of[s] != caller)
                        r.status = STATUS_REFUSED;
                    else
                    begin
                        in_use[s]     = 1'b0;
                        holder[s]     = '0;
                        parent_of[s]  = NO_ID;
                        has_exited[s] = 1'b0;
                        exit_value[s] = MARK_RELEASE;
                        if (live > 0)
                            live--;
                    end
                end
                KIND_EXIT:
                begin
                    if (target == NO_ID || !in_use[s] || holder[s] != target)
                        r.status = STATUS_NO_ID;
                    else
                    begin
                        has_exited[s] = 1'b1;
                        exit_value[s] = code;
                    end
                end
                default:
                    r.status = STATUS_REFUSED;
            endcase
            replies_due.push_back(r);
        endfunction

        // compare one response word with the oldest prediction
        function void check_reply(logic [STATUS_W-1:0] status, logic [ID_W-1:0] granted_id);
            pid_reply_t want;
            if (replies_due.size() == 0)
            begin
                $display("%0t: response status %0d id %0d with nothing expected",
                         $time, status, granted_id);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                errors++;
            end
            if (granted_id !== want.granted_id)
            begin
                $display("%0t: granted_id expected %0d actual %0d",
                         $time, want.granted_id, granted_id);
                errors++;
            end
        endfunction

        // random live entry other than the boot process, -1 when none fits
        function int pick_slot(pick_mode_t mode);
            int start;
            int s;
            start = $urandom_range(0, SLOTS - 1);
            for (int i = 0; i < SLOTS; i++)
            begin
                s = (start + i) % SLOTS;
                if (in_use[s] && holder[s] != ID_W'(BOOT) &&
                    (mode == PICK_ANY || has_exited[s] == (mode == PICK_EXITED)))
                    return s;
            end
            return -1;
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    int              cycle_count = 0;
    int              burst_left;
    int              ready_run = 0;
    bit              ready_flag;
    pid_table_shadow shadow;

    pia_req_if req_ch ();
    pia_rsp_if rsp_ch ();

    process_id_slot_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // drive one request word; bursts of back-to-back words with random gaps between
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] target,
                                input logic [ID_W-1:0] caller, input logic [CODE_W-1:0] code);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 10);
        end
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= kind;
        req_ch.target_id <= target;
        req_ch.caller_id <= caller;
        req_ch.exit_code <= code;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        shadow.note_request(kind, target, caller, code);
        burst_left--;
        @(negedge clk);
    endtask

    // one random word: allocate with the given share, else a release, exit or noise
    task automatic send_random_word(input int alloc_share);
        int                slot;
        int                roll;
        logic [KIND_W-1:0] k;
        logic [ID_W-1:0]   t;
        logic [ID_W-1:0]   c;
        logic [CODE_W-1:0] x;
        // noise by default: random kind other than allocate, random ids
        k = KIND_W'($urandom_range(1, 3));
        t = ID_W'($urandom);
        c = ID_W'($urandom);
        x = $urandom;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < alloc_share)
            k = KIND_ALLOC;
        else if (roll < 45)
        begin
            // well-formed release by the parent
            slot = shadow.pick_slot(PICK_RUNNING);
            if (slot >= 0)
            begin
                k = KIND_RELEASE;
                t = shadow.holder[slot];
                c = shadow.parent_of[slot];
            end
        end
        else if (roll < 62)
        begin
            slot = shadow.pick_slot(PICK_ANY);
            if (slot >= 0)
            begin
                k = KIND_EXIT;
                t = shadow.holder[slot];
            end
        end
        else if (roll < 75)
        begin
            // release by someone other than the parent
            slot = shadow.pick_slot(PICK_RUNNING);
            if (slot >= 0)
            begin
                k = KIND_RELEASE;
                t = shadow.holder[slot];
                c = shadow.parent_of[slot] ^ ID_W'($urandom_range(1, 32767));
            end
        end
        else if (roll < 83)
        begin
            // release of an id that already exited
            slot = shadow.pick_slot(PICK_EXITED);
            if (slot >= 0)
            begin
                k = KIND_RELEASE;
                t = shadow.holder[slot];
                c = shadow.parent_of[slot];
            end
        end
        send_request(k, t, c, x);
    endtask

    // receiver: runs of ready and runs of stall of random length
    always @(negedge clk)
    begin
        if (ready_run == 0)
        begin
            ready_flag = ($urandom_range(0, 2) != 0);
            ready_run  = ready_flag ? $urandom_range(1, 50) : $urandom_range(1, 14);
            rsp_ch.ready <= ready_flag;
        end
        ready_run = ready_run - 1;
    end

    // response check
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            shadow.check_reply(rsp_ch.status, rsp_ch.granted_id);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("** process_id_slot_allocator: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int slot;
        int guard;
        int tail;
        rst_n            = 1'b0;
        burst_left       = 0;
        req_ch.valid     = 1'b0;
        req_ch.kind      = KIND_ALLOC;
        req_ch.target_id = '0;
        req_ch.caller_id = '0;
        req_ch.exit_code = '0;
        shadow = new;
        shadow.clear();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: unused kind, out-of-range and absent ids, boot process
        send_request(KIND_UNUSED, '0, '0, '0);
        send_request(KIND_RELEASE, NO_ID, NO_ID, '0);
        send_request(KIND_RELEASE, ID_W'(BOOT), NO_ID, '0);
        send_request(KIND_RELEASE, '1, NO_ID, '0);
        send_request(KIND_EXIT, NO_ID, NO_ID, 32'h0000_1234);
        send_request(KIND_EXIT, ID_W'(BOOT), NO_ID, 32'h8000_0000);
        // repeated exit overwrites the status
        send_request(KIND_EXIT, ID_W'(BOOT), '1, 32'h7FFF_FFFF);
        // allocate with extreme callers, then refused and accepted releases
        send_request(KIND_ALLOC, '1, NO_ID, '1);
        send_request(KIND_ALLOC, '0, '1, '0);
        send_request(KIND_RELEASE, ID_W'(FIRST_ID), ID_W'(5), '0);
        send_request(KIND_RELEASE, ID_W'(FIRST_ID), NO_ID, '0);
        send_request(KIND_RELEASE, ID_W'(FIRST_ID), NO_ID, '0);
        send_request(KIND_EXIT, ID_W'(FIRST_ID + 1), NO_ID, 32'hFFFF_FFFF);
        send_request(KIND_RELEASE, ID_W'(FIRST_ID + 1), '1, '0);
        // slot free, or holding a different id
        send_request(KIND_EXIT, ID_W'(FIRST_ID + SLOTS), NO_ID, '0);
        send_request(KIND_ALLOC, '0, ID_W'(1), '0);
        send_request(KIND_EXIT, ID_W'(FIRST_ID + 2 + SLOTS), NO_ID, '0);
        send_request(KIND_RELEASE, ID_W'(FIRST_ID + 2 + SLOTS), ID_W'(1), '0);
        send_request(KIND_UNUSED, '1, '1, '1);
        send_request(KIND_RELEASE, ID_W'(FIRST_ID + 2), ID_W'(1), '0);

        // fill the table, mostly allocates, then hit it while full
        guard = 0;
        while (shadow.live < SLOTS && guard < 400)
        begin
            send_random_word(85);
            guard++;
        end
        send_request(KIND_ALLOC, ID_W'($urandom), ID_W'($urandom), $urandom);
        send_request(KIND_ALLOC, ID_W'($urandom), ID_W'($urandom), $urandom);

        // near-full sweep: free one slot, allocate again, so most scans run the
        // whole table and the candidate walks the id range until it wraps
        guard = 0;
        tail  = 0;
        while ((shadow.wraps == 0 || tail < 4) && guard < 700)
        begin
            if (shadow.wraps != 0)
                tail++;
            slot = int'(shadow.last_grant) % SLOTS;
            if (!shadow.in_use[slot] || shadow.holder[slot] != shadow.last_grant ||
                shadow.has_exited[slot])
                slot = shadow.pick_slot(PICK_RUNNING);
            if (slot < 0)
                break;
            send_request(KIND_RELEASE, shadow.holder[slot], shadow.parent_of[slot], $urandom);
            send_request(KIND_ALLOC, ID_W'($urandom), ID_W'($urandom), $urandom);
            if ($urandom_range(0, 11) == 0)
                send_random_word(10);
            guard++;
        end

        // mixed traffic
        for (int n = 0; n < 100; n++)
            send_random_word(35);

        // drain
        req_ch.valid <= 1'b0;
        while (shadow.replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (shadow.errors == 0)
            $display("** process_id_slot_allocator: PASSED **");
        else
            $display("** process_id_slot_allocator: FAILED **");
        $finish;
    end

endmodule
